### hw/rtl/srtr_pkg.sv
`timescale 1ns / 1ps

package srtr_pkg;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [2:0]  cell_index;
		logic [7:0]  target_char;
		logic        target_dot;
		logic [31:0] seed;
	} srtr_in_t;

	typedef struct packed {
		logic [2:0] out_cell;
		logic [7:0] shown_char;
		logic       dot_on;
		logic       last;
		logic       all_done;
	} srtr_out_t;

	localparam logic [1:0] REQ_LOAD  = 2'd0;
	localparam logic [1:0] REQ_START = 2'd1;
	localparam logic [1:0] REQ_TICK  = 2'd2;

	localparam logic [1:0] CFG_SPIN_DELAY = 2'd0;
	localparam logic [1:0] CFG_MAX_SPIN   = 2'd1;

	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_BASE  = 8'h20;

endpackage

### hw/rtl/srtr_cell_mem.sv
`timescale 1ns / 1ps

module srtr_cell_mem #(
	parameter int DEPTH = 8
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [7:0]                                 wr_char,
	input  logic                                       wr_dot,
	input  logic                                       rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [7:0]                                 rd_char,
	output logic                                       rd_dot
);
	import srtr_pkg::*;

	logic [7:0]       char_mem [DEPTH];
	logic             dot_mem  [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [7:0]       rd_char_q;
	logic             rd_dot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			char_mem[wr_addr] <= wr_char;
			dot_mem[wr_addr]  <= wr_dot;
		end
		if (rd_en) begin
			rd_char_q <= valid_q[rd_addr] ? char_mem[rd_addr] : CHAR_SPACE;
			rd_dot_q  <= valid_q[rd_addr] & dot_mem[rd_addr];
		end
	end

	assign rd_char = rd_char_q;
	assign rd_dot  = rd_dot_q;

endmodule

### hw/rtl/srtr_draw.sv
`timescale 1ns / 1ps

module srtr_draw (
	input  logic        clk,
	input  logic [31:0] x,
	output logic [7:0]  chr
);
	import srtr_pkg::*;

	localparam logic [31:0] RECIP95 = 32'd2893451652;
	localparam logic [7:0]  MOD     = 8'd95;

	logic [63:0] prod_s2;
	logic [31:0] x_s2;
	logic [25:0] quot;
	logic [32:0] quot_x95;
	logic [31:0] rem_full;
	logic [7:0]  r_s3;
	logic [7:0]  r_fix;

	assign quot     = prod_s2[63:38];
	assign quot_x95 = 33'(quot) * 33'(MOD);
	assign rem_full = x_s2 - quot_x95[31:0];

	always_ff @(posedge clk) begin
		prod_s2 <= 64'(x) * 64'(RECIP95);
		x_s2    <= x;
		r_s3    <= rem_full[7:0];
	end

	assign r_fix = (r_s3 >= MOD) ? (r_s3 - MOD) : r_s3;
	assign chr   = r_fix + CHAR_BASE;

endmodule

### hw/rtl/slot_reel_text_reveal_top.sv
`timescale 1ns / 1ps
// Channel | Direction | Handshake             | Payload
// req     | in        | req_valid / req_ready | req (srtr_in_t)
// rsp     | out       | rsp_valid / rsp_ready | rsp (srtr_out_t)
// cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Load, start and ticks that start no spin step are handled in IDLE. A spin step walks the
// CELLS entries of the target memory one per cycle, then drains the 3-stage draw
// pipeline (one 32x32 reciprocal multiply), then sends one result per cycle unless stalled.
// Reset is asynchronous on arst_n; unloaded targets read as space through per-entry
// valid bits, no clear pass. rsp_ready low stalls the result sequence; req is taken
// again once the last result of a step sits in the output register.

module slot_reel_text_reveal_top #(
	parameter int CELLS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  srtr_pkg::srtr_in_t  req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output srtr_pkg::srtr_out_t rsp,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data
);
	import srtr_pkg::*;

	localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int CNT_W = $clog2(CELLS + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CELLS - 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_WALK  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	function automatic logic [31:0] xorshift32(input logic [31:0] v);
		logic [31:0] a;
		logic [31:0] b;
		a = v ^ (v << 13);
		b = a ^ (a >> 17);
		return b ^ (b << 5);
	endfunction

	logic [1:0]       state_q;
	logic [15:0]      spin_delay_q;
	logic [15:0]      max_spin_q;
	logic [15:0]      since_start_q;
	logic [15:0]      since_spin_q;
	logic             finished_q;
	logic             past_q;
	logic [31:0]      rng_q;
	logic [CELLS-1:0] locked_q;
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] cnt_q;
	logic             all_locked_q;
	logic [IDX_W-1:0] eidx_q;

	logic             v_s1, v_s2, v_s3;
	logic [IDX_W-1:0] cell_s1, cell_s2, cell_s3;
	logic [7:0]       tgt_s2, tgt_s3;
	logic             dot_s2, dot_s3;

	logic [IDX_W-1:0] buf_cell [CELLS];
	logic [7:0]       buf_char [CELLS];
	logic             buf_dot  [CELLS];

	logic             rsp_valid_q;
	srtr_out_t        rsp_q;

	logic        req_fire;
	logic        issue;
	logic [15:0] ss_inc;
	logic [15:0] sp_inc;
	logic        mem_wr;
	logic [7:0]  rd_char;
	logic        rd_dot;
	logic [7:0]  draw_chr;
	logic        fin_lock;
	logic        pipe_busy;
	logic        emit_go;
	logic        emit_last;

	assign req_ready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign req_fire  = req_valid & req_ready;
	assign issue     = (state_q == ST_WALK) && !locked_q[idx_q];
	assign ss_inc    = (since_start_q == 16'hFFFF) ? since_start_q : since_start_q + 16'd1;
	assign sp_inc    = (since_spin_q == 16'hFFFF) ? since_spin_q : since_spin_q + 16'd1;
	assign mem_wr    = req_fire && (req.req_type == REQ_LOAD) && (int'(req.cell_index) < CELLS);
	assign fin_lock  = (draw_chr == tgt_s3) || past_q;
	assign pipe_busy = v_s1 | v_s2 | v_s3;
	assign emit_go   = (state_q == ST_EMIT) && (!rsp_valid_q || rsp_ready);
	assign emit_last = (CNT_W'(eidx_q) + CNT_W'(1)) == cnt_q;

	srtr_cell_mem #(
		.DEPTH(CELLS)
	) u_cell_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mem_wr),
		.wr_addr (IDX_W'(req.cell_index)),
		.wr_char (req.target_char),
		.wr_dot  (req.target_dot),
		.rd_en   (issue),
		.rd_addr (idx_q),
		.rd_char (rd_char),
		.rd_dot  (rd_dot)
	);

	srtr_draw u_draw (
		.clk (clk),
		.x   (rng_q),
		.chr (draw_chr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			spin_delay_q  <= 16'd50;
			max_spin_q    <= 16'd3000;
			since_start_q <= '0;
			since_spin_q  <= '0;
			finished_q    <= 1'b1;
			past_q        <= 1'b0;
			rng_q         <= 32'd1;
			locked_q      <= '0;
			idx_q         <= '0;
			cnt_q         <= '0;
			all_locked_q  <= 1'b1;
			eidx_q        <= '0;
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
			v_s3          <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_SPIN_DELAY: spin_delay_q <= cfg_data;
					CFG_MAX_SPIN:   max_spin_q <= cfg_data;
					default: ;
				endcase
			end

			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;

			case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						case (req.req_type)
							REQ_START: begin
								locked_q      <= '0;
								since_start_q <= '0;
								since_spin_q  <= '0;
								rng_q         <= req.seed | 32'd1;
								finished_q    <= 1'b0;
							end
							REQ_TICK: begin
								if (!finished_q) begin
									since_start_q <= ss_inc;
									if (sp_inc < spin_delay_q) begin
										since_spin_q <= sp_inc;
									end else begin
										since_spin_q <= '0;
										past_q       <= (ss_inc >= max_spin_q);
										idx_q        <= '0;
										cnt_q        <= '0;
										all_locked_q <= 1'b1;
										state_q      <= ST_WALK;
									end
								end
							end
							default: ;
						endcase
					end
				end
				ST_WALK: begin
					if (issue) begin
						rng_q <= xorshift32(rng_q);
					end
					if (idx_q == LAST_IDX) begin
						state_q <= ST_DRAIN;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_DRAIN: begin
					if (!pipe_busy) begin
						finished_q <= all_locked_q;
						eidx_q     <= '0;
						state_q    <= (cnt_q == '0) ? ST_IDLE : ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						if (emit_last) begin
							state_q <= ST_IDLE;
						end else begin
							eidx_q <= eidx_q + IDX_W'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (v_s3) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (fin_lock) begin
					locked_q[cell_s3] <= 1'b1;
				end else begin
					all_locked_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		cell_s1 <= idx_q;
		cell_s2 <= cell_s1;
		cell_s3 <= cell_s2;
		tgt_s2  <= rd_char;
		dot_s2  <= rd_dot;
		tgt_s3  <= tgt_s2;
		dot_s3  <= dot_s2;
		if (v_s3) begin
			buf_cell[cnt_q[IDX_W-1:0]] <= cell_s3;
			buf_char[cnt_q[IDX_W-1:0]] <= fin_lock ? tgt_s3 : draw_chr;
			buf_dot[cnt_q[IDX_W-1:0]]  <= fin_lock & dot_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit_go) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			rsp_q.out_cell   <= 3'(buf_cell[eidx_q]);
			rsp_q.shown_char <= buf_char[eidx_q];
			rsp_q.dot_on     <= buf_dot[eidx_q];
			rsp_q.last       <= emit_last;
			rsp_q.all_done   <= all_locked_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
